// ===== sv/rrcf_pkg.sv =====
// rotated rectangle corners and frame: shared package
// holds the request and result types, stage structs, angle constants and the sine table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrcf_pkg;

  // coordinate and angle formats
  localparam int COORD_BITS = 32;
  localparam int ANGLE_BITS = 16;
  localparam int TRIG_FRAC_DEFAULT = 15;

  // quarter-wave table format
  localparam int TABLE_FRAC = 15;
  localparam int TABLE_BITS = TABLE_FRAC + 1;
  localparam int IDX_BITS = 7;

  // degree constants
  localparam int DEG_FULL = 360;
  localparam int DEG_HALF = 180;
  localparam int DEG_QUARTER = 90;
  localparam int DEG_BITS = 9;

  // angle reduction: a whole number of turns makes every angle non-negative
  localparam int ANGLE_OFFSET = ((1 << (ANGLE_BITS - 1)) / DEG_FULL + 1) * DEG_FULL;
  localparam int ANGLE_SHIFT_FIX = ANGLE_OFFSET - (1 << (ANGLE_BITS - 1));
  localparam int POS_BITS = ANGLE_BITS + 1;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_BITS = 17;
  localparam int DEG_RECIP = (1 << RECIP_SHIFT) / DEG_FULL + 1;
  localparam int TURN_BITS = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // request and result payloads
  typedef struct packed {
    logic signed [COORD_BITS-1:0] rect_width;
    logic signed [COORD_BITS-1:0] rect_height;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [ANGLE_BITS-1:0] angle_deg;
  } rect_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] top_left_x;
    logic signed [COORD_BITS-1:0] top_left_y;
    logic signed [COORD_BITS-1:0] top_right_x;
    logic signed [COORD_BITS-1:0] top_right_y;
    logic signed [COORD_BITS-1:0] bottom_right_x;
    logic signed [COORD_BITS-1:0] bottom_right_y;
    logic signed [COORD_BITS-1:0] bottom_left_x;
    logic signed [COORD_BITS-1:0] bottom_left_y;
    logic [COORD_BITS-1:0]        frame_width;
    logic [COORD_BITS-1:0]        frame_height;
    logic                         input_error;
  } frame_t;

  // geometry carried between stages
  typedef struct packed {
    coord_t w;
    coord_t h;
    coord_t cx;
    coord_t cy;
    logic   err;
  } geom_t;

  // corners in order top left, top right, bottom right, bottom left
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
    logic         err;
  } corners_t;

  localparam int CORNER_TL = 0;
  localparam int CORNER_TR = 1;
  localparam int CORNER_BR = 2;
  localparam int CORNER_BL = 3;

  // sine of 0..90 degrees in Q1.15
  localparam logic [TABLE_BITS-1:0] QUARTER_SINE [0:DEG_QUARTER] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  function automatic logic [TABLE_BITS-1:0] quarter_sine(input logic [IDX_BITS-1:0] idx);
    logic [TABLE_BITS-1:0] val;
    if (idx > IDX_BITS'(DEG_QUARTER)) begin
      val = '0;
    end else begin
      val = QUARTER_SINE[idx];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rotated_rectangle_corners_and_frame_unit.sv =====
// rotated rectangle corners and frame: top level
// chains angle lookup, corner rotation and frame stages
// depends on rrcf_pkg, rrcf_angle, rrcf_rotate, rrcf_frame
//
// Usage:
//   A request on the rect channel (rect_valid/rect_ready/rect) carries width, height,
//   center and angle of one rectangle. The result on the frame channel
//   (frame_valid/frame_ready/frame) gives the four rotated corners, the axis-aligned
//   frame size and the error flag; one result per request, in request order.
//   Each request passes through five registers on its way to frame_valid: the
//   request with its turn estimate, the sine/cosine table result, the four 32-bit
//   by trig-width products, rounding with center add and saturation, and the
//   frame.
//   Throughput is one request per cycle; each of the five stage registers holds
//   one request and moves on whenever the stage after it is empty or moving.
//   When the receiver stalls, results stay in the stage registers and requests
//   are still taken until all five stages are full; then rect_ready drops.
//   Reset (rst, synchronous) empties every stage; no request is lost or duplicated
//   outside of reset.
`timescale 1ns / 1ps
`default_nettype none

module rotated_rectangle_corners_and_frame_unit import rrcf_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   rect_valid,
  output      logic   rect_ready,
  input  wire rect_t  rect,
  output      logic   frame_valid,
  input  wire logic   frame_ready,
  output      frame_t frame
);

  localparam int TW = TRIG_FRAC_BITS + 2;

  // angle to rotation link
  logic                 trig_valid;
  logic                 trig_ready;
  geom_t                geom;
  logic signed [TW-1:0] sin_val;
  logic signed [TW-1:0] cos_val;

  // rotation to frame link
  logic                 corner_valid;
  logic                 corner_ready;
  corners_t             corners;

  rrcf_angle #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_angle (
    .clk        (clk),
    .rst        (rst),
    .rect_valid (rect_valid),
    .rect_ready (rect_ready),
    .rect       (rect),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .geom       (geom),
    .sin_val    (sin_val),
    .cos_val    (cos_val)
  );

  rrcf_rotate #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk          (clk),
    .rst          (rst),
    .trig_valid   (trig_valid),
    .trig_ready   (trig_ready),
    .geom         (geom),
    .sin_val      (sin_val),
    .cos_val      (cos_val),
    .corner_valid (corner_valid),
    .corner_ready (corner_ready),
    .corners      (corners)
  );

  rrcf_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .corner_valid (corner_valid),
    .corner_ready (corner_ready),
    .corners      (corners),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame)
  );

endmodule

`default_nettype wire

// ===== sv/rrcf_angle.sv =====
// rotated rectangle corners and frame: angle reduction and sine/cosine lookup
// two pipeline stages: reciprocal-multiply modulo 360, then quarter-wave table
// depends on rrcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrcf_angle import rrcf_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            rect_valid,
  output      logic                            rect_ready,
  input  wire rect_t                           rect,
  output      logic                            trig_valid,
  input  wire logic                            trig_ready,
  output      geom_t                           geom,
  output      logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  output      logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int UP = (TRIG_FRAC_BITS >= TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
  localparam int DOWN = (TRIG_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
  localparam int RND = (DOWN > 0) ? (1 << (DOWN - 1)) : 0;
  localparam int SW = TABLE_BITS + UP;
  localparam int PROD_BITS = POS_BITS + RECIP_BITS;

  // signed sine of a reduced angle, rescaled to the trig format
  function automatic logic signed [TW-1:0] trig_of(input logic [DEG_BITS-1:0] d);
    logic [IDX_BITS-1:0] idx;
    logic                neg;
    logic [SW-1:0]       scaled;
    logic [SW:0]         rounded;
    logic [TW-1:0]       mag;
    if (d <= DEG_BITS'(DEG_QUARTER)) begin
      idx = IDX_BITS'(d);
      neg = 1'b0;
    end else if (d <= DEG_BITS'(DEG_HALF)) begin
      idx = IDX_BITS'(DEG_BITS'(DEG_HALF) - d);
      neg = 1'b0;
    end else if (d <= DEG_BITS'(DEG_HALF + DEG_QUARTER)) begin
      idx = IDX_BITS'(d - DEG_BITS'(DEG_HALF));
      neg = 1'b1;
    end else begin
      idx = IDX_BITS'(DEG_BITS'(DEG_FULL) - d);
      neg = 1'b1;
    end
    scaled = SW'(quarter_sine(idx)) << UP;
    rounded = (SW + 1)'(scaled) + (SW + 1)'(RND);
    mag = TW'(rounded >> DOWN);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // stage 1: offset angle to non-negative, estimate whole turns
  logic                  s1_valid;
  logic                  s1_ready;
  geom_t                 s1_geom;
  logic [POS_BITS-1:0]   s1_angle;
  logic [TURN_BITS-1:0]  s1_turns;
  logic [POS_BITS-1:0]   angle_pos;
  logic [PROD_BITS-1:0]  recip_prod;

  assign angle_pos = POS_BITS'({~rect.angle_deg[ANGLE_BITS-1], rect.angle_deg[ANGLE_BITS-2:0]})
                   + POS_BITS'(ANGLE_SHIFT_FIX);
  assign recip_prod = PROD_BITS'(angle_pos) * PROD_BITS'(DEG_RECIP);

  // stage 2 handshake
  logic s2_valid;
  logic s2_ready;

  assign s1_ready = !s1_valid || s2_ready;
  assign rect_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= rect_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && rect_valid) begin
      s1_geom.w   <= rect.rect_width;
      s1_geom.h   <= rect.rect_height;
      s1_geom.cx  <= rect.center_x;
      s1_geom.cy  <= rect.center_y;
      s1_geom.err <= rect.rect_width[COORD_BITS-1] | rect.rect_height[COORD_BITS-1];
      s1_angle    <= angle_pos;
      s1_turns    <= recip_prod[RECIP_SHIFT +: TURN_BITS];
    end
  end

  // stage 2: remainder, cosine angle, table lookups
  logic [DEG_BITS-1:0]  sin_deg;
  logic [DEG_BITS-1:0]  cos_sum;
  logic [DEG_BITS-1:0]  cos_deg;

  assign sin_deg = DEG_BITS'(s1_angle - POS_BITS'(POS_BITS'(s1_turns) * POS_BITS'(DEG_FULL)));
  assign cos_sum = sin_deg + DEG_BITS'(DEG_QUARTER);
  assign cos_deg = (cos_sum >= DEG_BITS'(DEG_FULL)) ? cos_sum - DEG_BITS'(DEG_FULL) : cos_sum;

  assign s2_ready = !s2_valid || trig_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      geom    <= s1_geom;
      sin_val <= trig_of(sin_deg);
      cos_val <= trig_of(cos_deg);
    end
  end

  assign trig_valid = s2_valid;

endmodule

`default_nettype wire

// ===== sv/rrcf_rotate.sv =====
// rotated rectangle corners and frame: corner rotation
// two pipeline stages: four size-by-trig products, then rounding, center add and saturation
// depends on rrcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrcf_rotate import rrcf_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             trig_valid,
  output      logic                             trig_ready,
  input  wire geom_t                            geom,
  input  wire logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  input  wire logic signed [TRIG_FRAC_BITS+1:0] cos_val,
  output      logic                             corner_valid,
  input  wire logic                             corner_ready,
  output      corners_t                         corners
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = COORD_BITS + TW;
  localparam int OW = PW + 2;
  localparam int SUMW = COORD_BITS + 3;
  localparam int RSHIFT = TRIG_FRAC_BITS + 1;

  // round half up, drop the halving and trig scale, add center, saturate
  function automatic coord_t place(input logic signed [OW-1:0] off, input coord_t center);
    logic signed [OW-1:0]   biased;
    logic signed [OW-1:0]   shifted;
    logic signed [SUMW-1:0] sum;
    coord_t                 res;
    biased = off + (OW'(1) <<< TRIG_FRAC_BITS);
    shifted = biased >>> RSHIFT;
    sum = SUMW'(shifted) + SUMW'(center);
    if ((&sum[SUMW-1:COORD_BITS-1]) || !(|sum[SUMW-1:COORD_BITS-1])) begin
      res = sum[COORD_BITS-1:0];
    end else if (sum[SUMW-1]) begin
      res = {1'b1, {(COORD_BITS - 1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS - 1){1'b1}}};
    end
    return res;
  endfunction

  // stage 3: products
  logic                 s3_valid;
  logic                 s3_ready;
  logic                 s4_valid;
  logic                 s4_ready;
  coord_t               s3_cx;
  coord_t               s3_cy;
  logic                 s3_err;
  logic signed [PW-1:0] s3_wc;
  logic signed [PW-1:0] s3_hs;
  logic signed [PW-1:0] s3_ws;
  logic signed [PW-1:0] s3_hc;

  assign s3_ready = !s3_valid || s4_ready;
  assign trig_ready = s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= trig_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && trig_valid) begin
      s3_cx  <= geom.cx;
      s3_cy  <= geom.cy;
      s3_err <= geom.err;
      s3_wc  <= PW'(geom.w) * PW'(cos_val);
      s3_hs  <= PW'(geom.h) * PW'(sin_val);
      s3_ws  <= PW'(geom.w) * PW'(sin_val);
      s3_hc  <= PW'(geom.h) * PW'(cos_val);
    end
  end

  // stage 4: corner offsets by sign pattern
  logic signed [OW-1:0] wc;
  logic signed [OW-1:0] hs;
  logic signed [OW-1:0] ws;
  logic signed [OW-1:0] hc;
  corners_t             corners_next;

  assign wc = OW'(s3_wc);
  assign hs = OW'(s3_hs);
  assign ws = OW'(s3_ws);
  assign hc = OW'(s3_hc);

  always_comb begin
    corners_next.x[CORNER_TL] = place(-wc - hs, s3_cx);
    corners_next.y[CORNER_TL] = place(-ws + hc, s3_cy);
    corners_next.x[CORNER_TR] = place(wc - hs, s3_cx);
    corners_next.y[CORNER_TR] = place(ws + hc, s3_cy);
    corners_next.x[CORNER_BR] = place(wc + hs, s3_cx);
    corners_next.y[CORNER_BR] = place(ws - hc, s3_cy);
    corners_next.x[CORNER_BL] = place(-wc + hs, s3_cx);
    corners_next.y[CORNER_BL] = place(-ws - hc, s3_cy);
    corners_next.err = s3_err;
  end

  assign s4_ready = !s4_valid || corner_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      corners <= corners_next;
    end
  end

  assign corner_valid = s4_valid;

endmodule

`default_nettype wire

// ===== sv/rrcf_frame.sv =====
// rotated rectangle corners and frame: bounding frame and result register
// min/max over the four corners, size subtract, error zeroing
// depends on rrcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrcf_frame import rrcf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     corner_valid,
  output      logic     corner_ready,
  input  wire corners_t corners,
  output      logic     frame_valid,
  input  wire logic     frame_ready,
  output      frame_t   frame
);

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  // two-level min/max trees
  coord_t xmin;
  coord_t xmax;
  coord_t ymin;
  coord_t ymax;
  frame_t frame_next;

  assign xmin = cmin(cmin(corners.x[0], corners.x[1]), cmin(corners.x[2], corners.x[3]));
  assign xmax = cmax(cmax(corners.x[0], corners.x[1]), cmax(corners.x[2], corners.x[3]));
  assign ymin = cmin(cmin(corners.y[0], corners.y[1]), cmin(corners.y[2], corners.y[3]));
  assign ymax = cmax(cmax(corners.y[0], corners.y[1]), cmax(corners.y[2], corners.y[3]));

  // result assembly, all zero with the error flag on a negative size
  always_comb begin
    if (corners.err) begin
      frame_next = '0;
      frame_next.input_error = 1'b1;
    end else begin
      frame_next.top_left_x     = corners.x[CORNER_TL];
      frame_next.top_left_y     = corners.y[CORNER_TL];
      frame_next.top_right_x    = corners.x[CORNER_TR];
      frame_next.top_right_y    = corners.y[CORNER_TR];
      frame_next.bottom_right_x = corners.x[CORNER_BR];
      frame_next.bottom_right_y = corners.y[CORNER_BR];
      frame_next.bottom_left_x  = corners.x[CORNER_BL];
      frame_next.bottom_left_y  = corners.y[CORNER_BL];
      frame_next.frame_width    = COORD_BITS'(xmax - xmin);
      frame_next.frame_height   = COORD_BITS'(ymax - ymin);
      frame_next.input_error    = 1'b0;
    end
  end

  // output register
  assign corner_ready = !frame_valid || frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (corner_ready) begin
      frame_valid <= corner_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (corner_ready && corner_valid) begin
      frame <= frame_next;
    end
  end

endmodule

`default_nettype wire
